>>> rtl/blue_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blue_pkg
// Shared types and codes for the BLUE drop-probability tracker.
// ----------------------------------------------------------------------------
package blue_pkg;

    // Field widths
    localparam int unsigned PROB_W   = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    // Probability of 1.0 in Q0.16
    localparam logic [PROB_W-1:0] PROB_ONE = 16'hFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_INCREASE_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECREASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREEZE_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT     = 3'd3;

    // Reset values of the configuration registers
    localparam logic [PROB_W-1:0]  RST_INCREASE_STEP   = 16'd1343;
    localparam logic [PROB_W-1:0]  RST_DECREASE_STEP   = 16'd16;
    localparam logic [TIME_W-1:0]  RST_FREEZE_INTERVAL = 32'd100000;
    localparam logic [COUNT_W-1:0] RST_QUEUE_LIMIT     = 16'd100;

    // Event kinds
    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_DEQUEUE = 1'b1;

    // Result codes
    typedef enum logic [2:0] {
        OUT_ACCEPTED    = 3'd0,
        OUT_PROB_DROP   = 3'd1,
        OUT_FORCED_DROP = 3'd2,
        OUT_DEQUEUED    = 3'd3,
        OUT_EMPTY       = 3'd4
    } t_outcome;

    // Configuration register set
    typedef struct packed {
        logic [PROB_W-1:0]  increase_step;
        logic [PROB_W-1:0]  decrease_step;
        logic [TIME_W-1:0]  freeze_interval;
        logic [COUNT_W-1:0] queue_limit;
    } t_cfg;

    // One event
    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] now_time;
        logic [PROB_W-1:0] rand_u;
    } t_event;

    // One result
    typedef struct packed {
        t_outcome           outcome;
        logic [PROB_W-1:0]  drop_level;
        logic [COUNT_W-1:0] occupancy;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/blue_aqm_drop_probability.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blue_aqm_drop_probability
// BLUE-style admission and drop-probability tracker for a packet queue.
// ----------------------------------------------------------------------------
// Each event word enters an input register, is resolved combinationally
// against the queue state and leaves through a result register, so one event
// per clock is sustained while m_axis_tready is held; the result word is
// presented once its event moves on from the input register, which waits
// while the result register is full and not drained. The state update loop
// (count, probability and last-update time) closes combinationally. The input
// side keeps accepting while a result waits, until both registers are full.
// Configuration is always accepted and must be written while no event is in
// flight. Probability is unsigned Q0.16 with 16'hFFFF as 1.0.
// ----------------------------------------------------------------------------
module blue_aqm_drop_probability
    import blue_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // Event stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,  // now_time[31:0], rand_u[47:32]
    input  wire logic                 s_axis_tuser,  // mode[0]
    // Result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [39:0]               m_axis_tdata   // outcome[2:0], drop_level[18:3],
                                                     // occupancy[34:19], zero[39:35]
);

    t_cfg    w_cfg;
    t_event  r_event;
    logic    r_in_vld;
    t_result w_result;
    t_result r_result;
    logic    r_out_vld;
    logic    w_advance;
    logic    w_in_take;

    blue_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Move a word when the result register is free or being drained
    assign w_advance     = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_event.mode     <= s_axis_tuser;
            r_event.now_time <= s_axis_tdata[31:0];
            r_event.rand_u   <= s_axis_tdata[47:32];
        end
    end

    blue_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_event  (r_event),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_result.occupancy, r_result.drop_level,
                            r_result.outcome};

endmodule
`default_nettype wire

>>> rtl/blue_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blue_cfg_regs
// Configuration register file; writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module blue_cfg_regs
    import blue_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_write;

    // Always able to take a word
    assign o_cfg_ready = 1'b1;
    assign w_write     = i_cfg_valid;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (i_cfg_index)
                REG_INCREASE_STEP:   n_cfg.increase_step   = i_cfg_data[PROB_W-1:0];
                REG_DECREASE_STEP:   n_cfg.decrease_step   = i_cfg_data[PROB_W-1:0];
                REG_FREEZE_INTERVAL: n_cfg.freeze_interval = i_cfg_data[TIME_W-1:0];
                REG_QUEUE_LIMIT:     n_cfg.queue_limit     = i_cfg_data[COUNT_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.increase_step   <= RST_INCREASE_STEP;
            r_cfg.decrease_step   <= RST_DECREASE_STEP;
            r_cfg.freeze_interval <= RST_FREEZE_INTERVAL;
            r_cfg.queue_limit     <= RST_QUEUE_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> rtl/blue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blue_core
// Occupancy and drop-probability state with the per-event update rules.
// ----------------------------------------------------------------------------
module blue_core
    import blue_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_fire,
    input  wire t_event i_event,
    input  wire t_cfg   i_cfg,
    output t_result     o_result
);

    logic [PROB_W-1:0]  r_drop_prob;
    logic [TIME_W-1:0]  r_last_time;
    logic [COUNT_W-1:0] r_count;
    logic [PROB_W-1:0]  n_drop_prob;
    logic [TIME_W-1:0]  n_last_time;
    logic [COUNT_W-1:0] n_count;

    logic [TIME_W-1:0]  w_elapsed;
    logic               w_thawed;
    logic [PROB_W:0]    w_sum;
    logic [PROB_W-1:0]  w_prob_up;
    logic [PROB_W-1:0]  w_prob_down;
    logic               w_full;
    logic               w_empty;
    t_outcome           w_outcome;

    // Freeze check and saturating steps
    assign w_elapsed   = i_event.now_time - r_last_time;
    assign w_thawed    = (w_elapsed >= i_cfg.freeze_interval);
    assign w_sum       = {1'b0, r_drop_prob} + {1'b0, i_cfg.increase_step};
    assign w_prob_up   = w_sum[PROB_W] ? PROB_ONE : w_sum[PROB_W-1:0];
    assign w_prob_down = (r_drop_prob < i_cfg.decrease_step) ? '0
                       : (r_drop_prob - i_cfg.decrease_step);
    assign w_full      = (r_count >= i_cfg.queue_limit);
    assign w_empty     = (r_count == '0);

    // Apply the event
    always_comb begin
        n_drop_prob = r_drop_prob;
        n_last_time = r_last_time;
        n_count     = r_count;
        w_outcome   = OUT_ACCEPTED;
        if (i_event.mode == MODE_ARRIVAL) begin
            if (w_full) begin
                if (w_thawed) begin
                    n_drop_prob = w_prob_up;
                    n_last_time = i_event.now_time;
                end
                w_outcome = (i_event.rand_u <= n_drop_prob) ? OUT_PROB_DROP
                                                            : OUT_FORCED_DROP;
            end else begin
                n_count   = r_count + 1'b1;
                w_outcome = OUT_ACCEPTED;
            end
        end else begin
            if (w_empty) begin
                if (w_thawed) begin
                    n_drop_prob = w_prob_down;
                    n_last_time = i_event.now_time;
                end
                w_outcome = OUT_EMPTY;
            end else begin
                n_count   = r_count - 1'b1;
                w_outcome = OUT_DEQUEUED;
            end
        end
    end

    // Advance the state on each event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_prob <= '0;
            r_last_time <= '0;
            r_count     <= '0;
        end else if (i_fire) begin
            r_drop_prob <= n_drop_prob;
            r_last_time <= n_last_time;
            r_count     <= n_count;
        end
    end

    assign o_result.outcome    = w_outcome;
    assign o_result.drop_level = n_drop_prob;
    assign o_result.occupancy  = n_count;

endmodule
`default_nettype wire
